[rtl/rab_pkg.sv]
// Shared definitions for the adaptive buffer sizer: constants, sequencer states,
// divider control and the signal-band lookup. No dependencies.
package rab_pkg;

   localparam int SIZE_BITS_DEF = 20;
   localparam int OUT_W         = 21;
   localparam int PCT_W         = 8;
   localparam int SCORE_W       = 7;
   localparam int SCORE_QW      = 7;
   localparam int MIN_SIZE      = 256;
   localparam int BIG_LIMIT     = 655;
   localparam int PCT_DIV       = 100;
   localparam int CHANGE_MUL    = 10;
   localparam int BAND_D_DIV    = 5;

   localparam logic [31:0] HOLD_MS = 32'd5000;

   localparam logic [PCT_W-1:0] PCT_BAND_A = 8'd50;
   localparam logic [PCT_W-1:0] PCT_BAND_B = 8'd75;
   localparam logic [PCT_W-1:0] PCT_BAND_C = 8'd100;
   localparam logic [PCT_W-1:0] PCT_BAND_D = 8'd120;
   localparam logic [PCT_W-1:0] PCT_BAND_E = 8'd150;

   localparam logic signed [7:0] RSSI_EDGE_A = -8'sd60;
   localparam logic signed [7:0] RSSI_EDGE_B = -8'sd70;
   localparam logic signed [7:0] RSSI_EDGE_C = -8'sd80;
   localparam logic signed [7:0] RSSI_EDGE_D = -8'sd90;

   localparam logic [SCORE_W-1:0] SCORE_FULL = 7'd100;
   localparam logic [SCORE_W-1:0] SCORE_NONE = 7'd0;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b00000000001,
      ST_RCP_T  = 11'b00000000010,
      ST_FIX_T  = 11'b00000000100,
      ST_EVAL   = 11'b00000001000,
      ST_MUL_D  = 11'b00000010000,
      ST_DECIDE = 11'b00000100000,
      ST_MUL_S  = 11'b00001000000,
      ST_SCORE  = 11'b00010000000,
      ST_DIV_S  = 11'b00100000000,
      ST_FIN_S  = 11'b01000000000,
      ST_OUT    = 11'b10000000000
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctrl_type;

   function automatic logic [PCT_W-1:0] band_pct(input logic signed [7:0] rssi);
      logic [PCT_W-1:0] pct;
      if (rssi >= RSSI_EDGE_A) begin
         pct = PCT_BAND_A;
      end else if (rssi >= RSSI_EDGE_B) begin
         pct = PCT_BAND_B;
      end else if (rssi >= RSSI_EDGE_C) begin
         pct = PCT_BAND_C;
      end else if (rssi >= RSSI_EDGE_D) begin
         pct = PCT_BAND_D;
      end else begin
         pct = PCT_BAND_E;
      end
      return pct;
   endfunction

endpackage

[rtl/rab_div.sv]
// Restoring shift-subtract divider, one quotient bit per step.
// Depends on rab_pkg for the control struct.
module rab_div
   import rab_pkg::*;
#(
   parameter int W  = SIZE_BITS_DEF + 9,
   parameter int QW = SIZE_BITS_DEF + 1
) (
   input  logic         clock,
   input  div_ctrl_type ctrl,
   input  logic [W-1:0] num_in,
   input  logic [W-1:0] dvs_in,
   output logic [QW-1:0] quo_out
);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  d_ff, d_in;
   logic [QW-1:0] q_ff, q_in;

   always_comb begin
      rem_in = rem_ff;
      d_in   = d_ff;
      q_in   = q_ff;
      priority if (ctrl.load) begin
         rem_in = num_in;
         d_in   = dvs_in;
         q_in   = '0;
      end else if (ctrl.step) begin
         if (rem_ff >= d_ff) begin
            rem_in = rem_ff - d_ff;
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         d_in = d_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      d_ff   <= d_in;
      q_ff   <= q_in;
   end

   assign quo_out = q_ff;

endmodule

[rtl/rssi_adaptive_buffer_sizer.sv]
// Sequence: an accepted item steps through RCP_T, FIX_T, EVAL, MUL_D, DECIDE, MUL_S and SCORE,
//   then through DIV_S and FIN_S when a score division is needed, and is registered out in OUT.
// Flow: no new item is taken until the last result is registered, as set by the sequencer
//   and the bit-serial score divider; a result still waiting in the output stalls the input.
// Reset: synchronous, active high; base and current size 4096, last time and count 0.
module rssi_adaptive_buffer_sizer
   import rab_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [SIZE_BITS-1:0]       csr_base_size,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [7:0]          req_rssi_dbm,
   input  logic [31:0]                req_now_ms,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [OUT_W-1:0]           rsp_buffer_size,
   output logic [OUT_W-1:0]           rsp_target_size,
   output logic                       rsp_adjusted,
   output logic                       rsp_rate_held,
   output logic [31:0]                rsp_adjust_total,
   output logic [SCORE_W-1:0]         rsp_efficiency_score
);

   localparam int CW     = SIZE_BITS + 1;
   localparam int PW     = CW + PCT_W;
   localparam int RCP_W  = 2 * SIZE_BITS;
   localparam int STEP_W = $clog2(SCORE_QW);
   localparam logic [SIZE_BITS-1:0] FIFTH_MUL =
      SIZE_BITS'((64'd1 << SIZE_BITS) / 64'(BAND_D_DIV));

   state_type            state_ff, state_in;
   logic [SIZE_BITS-1:0] base_ff, base_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic [31:0]          last_ff, last_in;
   logic [31:0]          cnt_ff, cnt_in;
   logic [PCT_W-1:0]     pct_ff, pct_in;
   logic [31:0]          now_ff, now_in;
   logic [CW-1:0]        tgt_ff, tgt_in;
   logic [SIZE_BITS-1:0] fifth_ff, fifth_in;
   logic                 held_ff, held_in;
   logic                 adj_ff, adj_in;
   logic [SCORE_W-1:0]   score_ff, score_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_buf_ff, rsp_buf_in;
   logic [OUT_W-1:0]     rsp_tgt_ff, rsp_tgt_in;
   logic                 rsp_adj_ff, rsp_adj_in;
   logic                 rsp_held_ff, rsp_held_in;
   logic [31:0]          rsp_cnt_ff, rsp_cnt_in;
   logic [SCORE_W-1:0]   rsp_score_ff, rsp_score_in;

   logic [CW-1:0]        mul_a;
   logic [PCT_W-1:0]     mul_b;
   logic [CW-1:0]        abs_diff;
   logic [SCORE_W-1:0]   quo_score;
   logic [CW+OUT_W-1:0]  cur_wide;
   logic [CW+OUT_W-1:0]  tgt_wide;
   logic [RCP_W-1:0]     fifth_prod;
   logic [SIZE_BITS+1:0] fifth_x5;
   logic [SIZE_BITS+1:0] fifth_rem;
   logic [SIZE_BITS+1:0] base_x3;
   logic [CW-1:0]        band_raw;
   div_ctrl_type         div_ctrl;
   logic [PW-1:0]        div_num;
   logic [PW-1:0]        div_dvs;
   logic                 hold_hit;

   rab_div #(
      .W  (PW),
      .QW (SCORE_W)
   ) u_div (
      .clock   (clock),
      .ctrl    (div_ctrl),
      .num_in  (div_num),
      .dvs_in  (div_dvs),
      .quo_out (quo_score)
   );

   assign abs_diff = (tgt_ff >= cur_ff) ? (tgt_ff - cur_ff) : (cur_ff - tgt_ff);
   assign hold_hit = (last_ff != '0) && (now_ff >= last_ff) && ((now_ff - last_ff) < HOLD_MS);
   assign cur_wide = {{OUT_W{1'b0}}, cur_ff};
   assign tgt_wide = {{OUT_W{1'b0}}, tgt_ff};

   assign fifth_prod = RCP_W'(base_ff) * RCP_W'(FIFTH_MUL);
   assign fifth_x5   = {fifth_ff, 2'b00} + (SIZE_BITS+2)'(fifth_ff);
   assign fifth_rem  = (SIZE_BITS+2)'(base_ff) - fifth_x5;
   assign base_x3    = {1'b0, base_ff, 1'b0} + (SIZE_BITS+2)'(base_ff);

   always_comb begin
      unique case (pct_ff)
         PCT_BAND_A: begin
            band_raw = CW'(base_ff >> 1);
         end
         PCT_BAND_B: begin
            band_raw = CW'(base_x3 >> 2);
         end
         PCT_BAND_C: begin
            band_raw = CW'(base_ff);
         end
         PCT_BAND_D: begin
            band_raw = CW'(base_ff) + CW'(fifth_ff);
         end
         default: begin
            band_raw = CW'(base_x3 >> 1);
         end
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_MUL_D: begin
            mul_a = abs_diff;
            mul_b = PCT_W'(CHANGE_MUL);
         end
         default: begin
            mul_a = cur_ff;
            mul_b = PCT_W'(PCT_DIV);
         end
      endcase
   end

   assign prod_in = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      pct_in       = pct_ff;
      now_in       = now_ff;
      tgt_in       = tgt_ff;
      fifth_in     = fifth_ff;
      held_in      = held_ff;
      adj_in       = adj_ff;
      score_in     = score_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_buf_in   = rsp_buf_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      rsp_adj_in   = rsp_adj_ff;
      rsp_held_in  = rsp_held_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_score_in = rsp_score_ff;
      div_ctrl     = '0;
      div_num      = prod_ff;
      div_dvs      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               base_in = csr_base_size;
               cur_in  = {1'b0, csr_base_size};
            end else if (req_valid) begin
               pct_in   = band_pct(req_rssi_dbm);
               now_in   = req_now_ms;
               state_in = ST_RCP_T;
            end
         end
         ST_RCP_T: begin
            fifth_in = fifth_prod[RCP_W-1:SIZE_BITS];
            state_in = ST_FIX_T;
         end
         ST_FIX_T: begin
            if (fifth_rem >= (SIZE_BITS+2)'(BAND_D_DIV)) begin
               fifth_in = fifth_ff + 1'b1;
            end
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            tgt_in   = (band_raw < CW'(MIN_SIZE)) ? CW'(MIN_SIZE) : band_raw;
            held_in  = hold_hit;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            adj_in = !held_ff && (tgt_ff != cur_ff) &&
                     ((cur_ff == '0) || (prod_ff >= PW'(cur_ff)));
            if (adj_in) begin
               cur_in  = tgt_ff;
               cnt_in  = cnt_ff + 32'd1;
               last_in = now_ff;
            end
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            state_in = ST_SCORE;
         end
         ST_SCORE: begin
            priority if (cur_ff > CW'(BIG_LIMIT)) begin
               score_in = (cur_ff >= tgt_ff) ? SCORE_FULL : SCORE_NONE;
               state_in = ST_OUT;
            end else if (cur_ff >= tgt_ff) begin
               score_in = SCORE_FULL;
               state_in = ST_OUT;
            end else begin
               div_ctrl.load = 1'b1;
               div_dvs       = PW'(tgt_ff) << (SCORE_QW - 1);
               step_in       = '0;
               state_in      = ST_DIV_S;
            end
         end
         ST_DIV_S: begin
            div_ctrl.step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_W'(SCORE_QW - 1)) begin
               state_in = ST_FIN_S;
            end
         end
         ST_FIN_S: begin
            score_in = quo_score;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_buf_in   = cur_wide[OUT_W-1:0];
               rsp_tgt_in   = tgt_wide[OUT_W-1:0];
               rsp_adj_in   = adj_ff;
               rsp_held_in  = held_ff;
               rsp_cnt_in   = cnt_ff;
               rsp_score_in = score_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= SIZE_BITS'(4096);
         cur_ff       <= CW'(4096);
         last_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         cur_ff       <= cur_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pct_ff       <= pct_in;
      now_ff       <= now_in;
      tgt_ff       <= tgt_in;
      fifth_ff     <= fifth_in;
      held_ff      <= held_in;
      adj_ff       <= adj_in;
      score_ff     <= score_in;
      prod_ff      <= (state_ff == ST_MUL_D || state_ff == ST_MUL_S) ? prod_in : prod_ff;
      step_ff      <= step_in;
      rsp_buf_ff   <= rsp_buf_in;
      rsp_tgt_ff   <= rsp_tgt_in;
      rsp_adj_ff   <= rsp_adj_in;
      rsp_held_ff  <= rsp_held_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_score_ff <= rsp_score_in;
   end

   assign csr_ready            = (state_ff == ST_IDLE);
   assign req_ready            = (state_ff == ST_IDLE) && !csr_valid;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_buffer_size      = rsp_buf_ff;
   assign rsp_target_size      = rsp_tgt_ff;
   assign rsp_adjusted         = rsp_adj_ff;
   assign rsp_rate_held        = rsp_held_ff;
   assign rsp_adjust_total     = rsp_cnt_ff;
   assign rsp_efficiency_score = rsp_score_ff;

`ifndef SYNTHESIS
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && cnt_ff != $past(cnt_ff)) |-> (cnt_ff == $past(cnt_ff) + 32'd1))
      else $error("adjust count moved by other than one");

   a_adj_not_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_adjusted) |-> !rsp_rate_held)
      else $error("item both adjusted and rate held");

   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_efficiency_score <= SCORE_FULL))
      else $error("efficiency score above full scale");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("new item taken while sequencer busy");

   a_csr_loads_cur: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (cur_ff == {1'b0, base_ff}))
      else $error("base size write did not load current size");
`endif

endmodule

[tb/tb_rssi_adaptive_buffer_sizer.sv]
`timescale 1ns / 100ps
// Self-checking testbench for rssi_adaptive_buffer_sizer: signal samples go in through a
// queue-fed driver, a monitor checks each sizing result against a predictor of the block.
// Depends on rab_pkg and the block itself.
module tb_rssi_adaptive_buffer_sizer;
   import rab_pkg::*;

   localparam int SIZE_BITS        = SIZE_BITS_DEF;
   localparam int IDLE_PCT         = 18;
   localparam int RANDOM_PER_PHASE = 230;
   localparam int HOLD_AT_RESULT   = 350;
   localparam int HOLD_CYCLES      = 600;
   localparam int CALM_FROM        = 700;
   localparam int CALM_TO          = 1000;
   localparam int STALL_LIMIT      = 4000;
   localparam int DRAIN_CYCLES     = 80;
   localparam int FLOOR_BYTES      = 256;
   localparam int SCORE_EXACT_MAX  = 655;
   localparam logic [31:0] MIN_GAP_MS = 32'd5000;

   typedef struct {
      logic signed [7:0] rssi;
      logic [31:0]       now;
   } sample_type;

   typedef struct packed {
      logic [OUT_W-1:0]   buffer_size;
      logic [OUT_W-1:0]   target_size;
      logic               adjusted;
      logic               rate_held;
      logic [31:0]        adjust_total;
      logic [SCORE_W-1:0] score;
   } sizing_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [SIZE_BITS-1:0]     csr_base_size = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [7:0]        req_rssi_dbm = '0;
   logic [31:0]              req_now_ms = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [OUT_W-1:0]         rsp_buffer_size;
   logic [OUT_W-1:0]         rsp_target_size;
   logic                     rsp_adjusted;
   logic                     rsp_rate_held;
   logic [31:0]              rsp_adjust_total;
   logic [SCORE_W-1:0]       rsp_efficiency_score;

   sample_type samples_to_send[$];
   sizing_type sizings_due[$];

   logic [SIZE_BITS-1:0] base_bytes;
   longint               cur_size;
   logic [31:0]          last_resize_ms;
   logic [31:0]          resize_count;

   int  queued_total = 0;
   int  rsp_count = 0;
   int  fault_count = 0;
   int  hold_left = 0;
   int  stall_cycles = 0;
   logic calm;

   assign calm = (rsp_count >= CALM_FROM) && (rsp_count < CALM_TO);

   rssi_adaptive_buffer_sizer #(.SIZE_BITS(SIZE_BITS)) dut (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_base_size        (csr_base_size),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_rssi_dbm         (req_rssi_dbm),
      .req_now_ms           (req_now_ms),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_buffer_size      (rsp_buffer_size),
      .rsp_target_size      (rsp_target_size),
      .rsp_adjusted         (rsp_adjusted),
      .rsp_rate_held        (rsp_rate_held),
      .rsp_adjust_total     (rsp_adjust_total),
      .rsp_efficiency_score (rsp_efficiency_score)
   );

   always #1 clock = ~clock;

   function automatic sizing_type resize_step(input logic signed [7:0] rssi,
                                              input logic [31:0] now);
      sizing_type r;
      longint     tgt;
      longint     chg;
      longint     sc;
      int         pct;
      logic       held;
      logic       adj;
      if (rssi >= -60) begin
         pct = 50;
      end else if (rssi >= -70) begin
         pct = 75;
      end else if (rssi >= -80) begin
         pct = 100;
      end else if (rssi >= -90) begin
         pct = 120;
      end else begin
         pct = 150;
      end
      tgt = (longint'(base_bytes) * pct) / 100;
      if (tgt < FLOOR_BYTES) begin
         tgt = FLOOR_BYTES;
      end
      held = (last_resize_ms != 32'd0) && (now >= last_resize_ms) &&
             ((now - last_resize_ms) < MIN_GAP_MS);
      adj = 1'b0;
      if (!held && tgt != cur_size) begin
         if (cur_size == 0) begin
            adj = 1'b1;
         end else begin
            chg = ((tgt - cur_size) * 100) / cur_size;
            adj = (chg >= 10) || (chg <= -10);
         end
         if (adj) begin
            cur_size = tgt;
            resize_count = resize_count + 32'd1;
            last_resize_ms = now;
         end
      end
      if (cur_size > SCORE_EXACT_MAX) begin
         sc = (cur_size >= tgt) ? 100 : 0;
      end else begin
         sc = (cur_size * 100) / tgt;
         if (sc > 100) begin
            sc = 100;
         end
      end
      r.buffer_size  = OUT_W'(cur_size);
      r.target_size  = OUT_W'(tgt);
      r.adjusted     = adj;
      r.rate_held    = held;
      r.adjust_total = resize_count;
      r.score        = SCORE_W'(sc);
      return r;
   endfunction

   task automatic queue_sample(input logic signed [7:0] rssi, input logic [31:0] now);
      sample_type s;
      s.rssi = rssi;
      s.now  = now;
      samples_to_send.push_back(s);
      queued_total++;
   endtask

   task automatic write_base_size(input logic [SIZE_BITS-1:0] value);
      @(posedge clock);
      csr_valid     <= 1'b1;
      csr_base_size <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      base_bytes = value;
      cur_size   = longint'(value);
   endtask

   task automatic wait_all_results();
      while (rsp_count < queued_total) @(posedge clock);
   endtask

   always @(posedge clock) begin
      sample_type s;
      logic       offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            sizings_due.push_back(resize_step(req_rssi_dbm, req_now_ms));
         end
         if (!req_valid || req_ready) begin
            offer = (samples_to_send.size() != 0) &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT);
            if (offer) begin
               s = samples_to_send.pop_front();
               req_rssi_dbm <= s.rssi;
               req_now_ms   <= s.now;
            end
            req_valid <= offer;
         end
      end
   end

   always @(posedge clock) begin
      sizing_type want;
      sizing_type got;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.buffer_size  = rsp_buffer_size;
            got.target_size  = rsp_target_size;
            got.adjusted     = rsp_adjusted;
            got.rate_held    = rsp_rate_held;
            got.adjust_total = rsp_adjust_total;
            got.score        = rsp_efficiency_score;
            rsp_count++;
            if (sizings_due.size() == 0) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("result %0d arrived with nothing expected", rsp_count);
               end
            end else begin
               want = sizings_due.pop_front();
               if (got.buffer_size !== want.buffer_size ||
                   got.target_size !== want.target_size ||
                   got.adjusted !== want.adjusted ||
                   got.rate_held !== want.rate_held ||
                   got.adjust_total !== want.adjust_total ||
                   got.score !== want.score) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("result %0d mismatch (expected/actual): buffer %0d/%0d",
                              rsp_count, want.buffer_size, got.buffer_size);
                     $display("   target %0d/%0d adjusted %0b/%0b held %0b/%0b",
                              want.target_size, got.target_size, want.adjusted,
                              got.adjusted, want.rate_held, got.rate_held);
                     $display("   total %0d/%0d score %0d/%0d", want.adjust_total,
                              got.adjust_total, want.score, got.score);
                  end
               end
            end
            if (rsp_count == HOLD_AT_RESULT) begin
               hold_left = HOLD_CYCLES;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", stall_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic signed [7:0] r8;
      logic [31:0]       now;
      logic [31:0]       clock_ms;
      int                roll;
      base_bytes     = SIZE_BITS'(4096);
      cur_size       = 4096;
      last_resize_ms = 32'd0;
      resize_count   = 32'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset base of 4096: band edges, zero time, hold window edges, time going back
      queue_sample(-60, 32'd0);
      queue_sample(-61, 32'd100);
      queue_sample(127, 32'd4000);
      queue_sample(-128, 32'd5099);
      queue_sample(-128, 32'd5100);
      queue_sample(-128, 32'd50);
      queue_sample(-70, 32'd20000);
      queue_sample(-71, 32'd30000);
      queue_sample(-80, 32'd40000);
      queue_sample(-81, 32'd50000);
      queue_sample(-90, 32'd60000);
      queue_sample(-91, 32'd70000);
      queue_sample(-100, 32'hFFFF_FFFF);
      wait_all_results();

      // zero current size replaced whenever the rate is not held
      write_base_size('0);
      queue_sample(-60, 32'd80000);
      queue_sample(-128, 32'd80001);
      queue_sample(127, 32'd0);
      wait_all_results();

      // small sizes: change below ten percent, exact score
      write_base_size(SIZE_BITS'(270));
      queue_sample(-60, 32'd100000);
      queue_sample(-128, 32'd110000);
      queue_sample(-60, 32'd120000);
      queue_sample(-128, 32'd120001);
      wait_all_results();

      write_base_size('1);
      queue_sample(-91, 32'd130000);
      queue_sample(-60, 32'd130100);
      queue_sample(127, 32'd0);
      wait_all_results();

      clock_ms = 32'd200000;
      for (int p = 0; p < 8; p++) begin
         wait_all_results();
         case (p)
            0: write_base_size(SIZE_BITS'($urandom_range(0, (1 << SIZE_BITS) - 1)));
            1: write_base_size(SIZE_BITS'($urandom_range(200, 900)));
            2: write_base_size('1);
            3: write_base_size(SIZE_BITS'($urandom_range(1000, 20000)));
            4: write_base_size('0);
            5: write_base_size(SIZE_BITS'($urandom_range(256, 700)));
            6: write_base_size(SIZE_BITS'($urandom_range(0, (1 << SIZE_BITS) - 1)));
            default: write_base_size(SIZE_BITS'($urandom_range(400, 5000)));
         endcase
         if (p == 6) begin
            clock_ms = 32'hFFFF_0000;
         end
         repeat (RANDOM_PER_PHASE) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
               clock_ms = clock_ms + $urandom_range(0, 9000);
               now = clock_ms;
            end else if (roll < 85) begin
               clock_ms = clock_ms + $urandom_range(4990, 5010);
               now = clock_ms;
            end else if (roll < 93) begin
               now = $urandom();
            end else if (roll < 97) begin
               now = clock_ms - $urandom_range(1, 20000);
            end else begin
               now = 32'd0;
            end
            if ($urandom_range(0, 99) < 60) begin
               r8 = 8'(-100 + int'($urandom_range(0, 59)));
            end else begin
               r8 = 8'($urandom_range(0, 255));
            end
            queue_sample(r8, now);
         end
      end

      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sizings_due.size() != 0) begin
         fault_count++;
         $display("%0d expected results never arrived", sizings_due.size());
      end
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
